@@ design/text_console_cursor_writer_macros.svh @@
// Assertion macros shared by the cursor writer's checker.
`ifndef TEXT_CONSOLE_CURSOR_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_WRITER_MACROS_SVH

// Same-cycle implication, ignored while in reset.
`define TCCW_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, ignored while in reset.
`define TCCW_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define TCCW_ASSERT_ALWAYS_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ design/tccw_pkg.sv @@
// Types and constants shared by the text console cursor writer modules.
package tccw_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned TAB_STEP    = 4;

  localparam logic [7:0] CODE_BS   = 8'd8;
  localparam logic [7:0] CODE_TAB  = 8'd9;
  localparam logic [7:0] CODE_LF   = 8'd10;
  localparam logic [7:0] CODE_VT   = 8'd11;
  localparam logic [7:0] CODE_FF   = 8'd12;
  localparam logic [7:0] CODE_CR   = 8'd13;
  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] ATTR_RESET = 8'h0F;

  typedef enum logic [2:0] {
    OP_PRINT    = 3'd0,
    OP_NEWLINE  = 3'd1,
    OP_TAB      = 3'd2,
    OP_VTAB     = 3'd3,
    OP_HOME     = 3'd4,
    OP_BACK     = 3'd5
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
  } entry_t;

endpackage

@@ design/text_console_cursor_writer.sv @@
// Top level of the text console cursor writer.
//
// Input channel: in_valid/in_ready carry one character code per request.
// Output channel: out_valid/out_ready carry one result per character: the
// cell write flag, cell address and data, and the cursor after the character.
// cfg_write/cfg_data load the attribute byte placed in each written cell;
// write it only while no request is in flight.
// Throughput is one character per cycle while out_ready stays high. An accepted
// character passes through the request queue and then the result register,
// which takes the cursor update, before out_valid rises.
// Reset homes the cursor to column 0, row 0, sets the attribute to 0x0F and
// empties the queue. When the receiver stalls, the result register holds and
// the two-entry queue takes two more requests before in_ready drops.
// Cells that are not written report address and data as zero.
module text_console_cursor_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  char_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        cell_write,
  output logic [10:0] cell_address,
  output logic [15:0] cell_data,
  output logic [6:0]  cursor_column,
  output logic [4:0]  cursor_row
);
  import tccw_pkg::*;

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  tccw_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .push_ready (push_ready),
    .push_valid (push_valid),
    .push_entry (push_entry)
  );

  tccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  tccw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_entry     (pop_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cell_write    (cell_write),
    .cell_address  (cell_address),
    .cell_data     (cell_data),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row)
  );

endmodule

@@ design/tccw_front.sv @@
// Front end: accepts character requests and classifies them into operations.
module tccw_front (
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      char_code,
  input  logic            push_ready,
  output logic            push_valid,
  output tccw_pkg::entry_t push_entry
);
  import tccw_pkg::*;

  op_t op;

  always_comb begin
    unique case (char_code)
      CODE_CR, CODE_LF: op = OP_NEWLINE;
      CODE_TAB:         op = OP_TAB;
      CODE_VT:          op = OP_VTAB;
      CODE_FF:          op = OP_HOME;
      CODE_BS:          op = OP_BACK;
      default:          op = OP_PRINT;
    endcase
  end

  assign in_ready      = push_ready;
  assign push_valid    = in_valid;
  assign push_entry.op = op;
  assign push_entry.ch = char_code;

endmodule

@@ design/tccw_queue.sv @@
// Short queue of classified requests between front and back end.
module tccw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  tccw_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output tccw_pkg::entry_t pop_entry
);
  import tccw_pkg::*;

  localparam int unsigned PtrW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(QUEUE_DEPTH + 1);

  entry_t              slots [QUEUE_DEPTH];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CountW-1:0]   count;
  logic                push;
  logic                pop;

  assign push_ready = (count != CountW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CountW'(1);
        2'b01:   count <= count - CountW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

@@ design/tccw_back.sv @@
// Back end: cursor state, cell address and data, and the result register.
module tccw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [7:0]       cfg_data,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  tccw_pkg::entry_t pop_entry,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             cell_write,
  output logic [10:0]      cell_address,
  output logic [15:0]      cell_data,
  output logic [6:0]       cursor_column,
  output logic [4:0]       cursor_row
);
  import tccw_pkg::*;

  logic [7:0]  attr;
  logic [6:0]  column_pos;
  logic [4:0]  row_pos;
  logic [6:0]  column_pos_next;
  logic [4:0]  row_pos_next;
  logic [5:0]  row_plus;
  logic [4:0]  row_inc;
  logic [7:0]  col_sum;
  logic [6:0]  col_dec;
  logic [6:0]  addr_col;
  logic [11:0] addr_full;
  logic        wr;
  logic [7:0]  wr_char;
  logic        pop;

  assign pop       = pop_valid && pop_ready;
  assign pop_ready = !out_valid || out_ready;

  assign row_plus = {1'b0, row_pos} + 6'd1;
  assign row_inc  = (row_plus >= 6'(ROWS)) ? '0 : row_plus[4:0];
  assign col_dec  = (column_pos == '0) ? '0 : column_pos - 7'd1;
  assign col_sum  = {1'b0, column_pos} +
                    ((pop_entry.op == OP_TAB) ? 8'(TAB_STEP) : 8'd1);

  always_comb begin
    column_pos_next = column_pos;
    row_pos_next    = row_pos;
    wr              = 1'b0;
    wr_char         = pop_entry.ch;
    addr_col        = column_pos;
    unique case (pop_entry.op)
      OP_NEWLINE: begin
        column_pos_next = '0;
        row_pos_next    = row_inc;
      end
      OP_VTAB: begin
        row_pos_next = row_inc;
      end
      OP_HOME: begin
        column_pos_next = '0;
        row_pos_next    = '0;
      end
      OP_BACK: begin
        column_pos_next = col_dec;
        addr_col        = col_dec;
        wr              = 1'b1;
        wr_char         = SPACE_CHAR;
      end
      OP_TAB, OP_PRINT: begin
        wr = (pop_entry.op == OP_PRINT);
        // wrap onto the next row once the column runs past the line
        if (col_sum >= 8'(COLUMNS)) begin
          column_pos_next = 7'(col_sum - 8'(COLUMNS));
          row_pos_next    = row_inc;
        end else begin
          column_pos_next = col_sum[6:0];
        end
      end
      default: begin
        column_pos_next = column_pos;
        row_pos_next    = row_pos;
      end
    endcase
  end

  assign addr_full = 12'(row_pos) * 12'(COLUMNS) + 12'(addr_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      attr       <= ATTR_RESET;
      column_pos <= '0;
      row_pos    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        attr <= cfg_data;
      end
      if (pop) begin
        column_pos <= column_pos_next;
        row_pos    <= row_pos_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cell_write    <= wr;
      cell_address  <= wr ? addr_full[10:0] : '0;
      cell_data     <= wr ? {attr, wr_char} : '0;
      cursor_column <= column_pos_next;
      cursor_row    <= row_pos_next;
    end
  end

endmodule

@@ design/tccw_checker.sv @@
// Port-level checker for the text console cursor writer, bound to the top.
`include "text_console_cursor_writer_macros.svh"

module tccw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        cell_write,
  input logic [10:0] cell_address,
  input logic [15:0] cell_data,
  input logic [6:0]  cursor_column,
  input logic [4:0]  cursor_row
);

  `TCCW_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(cell_write) && $stable(cell_address) && $stable(cell_data) && $stable(cursor_column) && $stable(cursor_row), "stalled result changed")
  `TCCW_ASSERT_NOW(a_idle_cell_zero, out_valid && !cell_write, cell_address == '0 && cell_data == '0, "cell fields not zero without a write")
  `TCCW_ASSERT_NOW(a_cursor_range, out_valid, (32'(cursor_column) < COLUMNS) && (32'(cursor_row) < ROWS), "cursor out of screen")
  `TCCW_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid, "result valid right after reset")

endmodule

bind text_console_cursor_writer tccw_checker #(
  .COLUMNS (COLUMNS),
  .ROWS    (ROWS)
) u_tccw_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .cell_write    (cell_write),
  .cell_address  (cell_address),
  .cell_data     (cell_data),
  .cursor_column (cursor_column),
  .cursor_row    (cursor_row)
);
